// ----- rtl/mprd_pkg.sv -----
package mprd_pkg;

   typedef enum logic [2:0] {
      PH_COUNT  = 3'd0,
      PH_TUPLES = 3'd1,
      PH_WBXML  = 3'd2,
      PH_BODY   = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TUPLE    = 3'd0,
      KIND_WBXML    = 3'd1,
      KIND_BODY     = 3'd2,
      KIND_ZERO_ERR = 3'd3,
      KIND_EMPTY    = 3'd4
   } kind_type;

   // Last byte position of the count header and of a tuple.
   localparam logic [2:0] COUNT_LAST_BYTE = 3'd3;
   localparam logic [2:0] TUPLE_LAST_BYTE = 3'd7;

   // Number of result words the output queue holds.
   localparam logic [1:0] QUEUE_FULL = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [31:0] part_index;
      logic [31:0] part_offset;
      logic [31:0] part_size;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic       extra_empty;
      result_type result;
   } parse_out_type;

   localparam result_type EMPTY_MARKER = '{
      kind:        KIND_EMPTY,
      data_byte:   8'd0,
      part_index:  32'd0,
      part_offset: 32'd0,
      part_size:   32'd0,
      last:        1'b1
   };

endpackage

// ----- rtl/mprd_if.sv -----
interface mprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       msg_start;

   modport source (output valid, output byte_value, output msg_start, input ready);
   modport sink (input valid, input byte_value, input msg_start, output ready);
endinterface

interface mprd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [31:0] part_index;
   logic [31:0] part_offset;
   logic [31:0] part_size;
   logic        last;

   modport source (output valid, output kind, output data_byte, output part_index,
                   output part_offset, output part_size, output last, input ready);
   modport sink (input valid, input kind, input data_byte, input part_index,
                 input part_offset, input part_size, input last, output ready);
endinterface

// ----- rtl/multipart_response_deframer_unit.sv -----
// Multipart response deframer. One byte word of the response stream is taken
// per clock cycle while req_chan.ready is high; its results are registered in
// the output queue. A four-byte little-endian part count is followed
// by eight-byte tuples (offset, size), each reported as a tuple word; then the
// first part's bytes come out as WBXML words with the final one marked, and
// all later bytes as body words. A zero part count gives one error word and
// the rest of the message is dropped until msg_start. The response side is a
// two-word queue, so req_chan.ready does not depend on rsp_chan.ready in the
// same cycle; it drops only while the queue is full or while the extra
// empty-part marker that follows the last tuple of an empty first part is
// not yet in the queue. Writing csr_write_data to 0 makes the block
// swallow every byte (msg_start still clears the parser state).
module multipart_response_deframer_unit
   import mprd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   mprd_req_if.sink          req_chan,
   mprd_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   logic          enable_ff;
   parse_out_type parse_out;
   logic          accept;
   logic          pop;
   logic          push;
   result_type    push_data;
   result_type    head_ff, head_in;
   result_type    tail_ff, tail_in;
   logic [1:0]    count_ff, count_in;
   logic          pend_ff, pend_in;

   assign req_chan.ready = !pend_ff && (count_ff != QUEUE_FULL);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   mprd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable_ff),
      .accept     (accept),
      .byte_value (req_chan.byte_value),
      .msg_start  (req_chan.msg_start),
      .parse_out  (parse_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         enable_ff <= csr_write_data;
      end
   end

   // A pending marker blocks new bytes, so it never competes with a parser word.
   always_comb begin
      if (pend_ff) begin
         push      = (count_ff != QUEUE_FULL) || pop;
         push_data = EMPTY_MARKER;
      end else begin
         push      = parse_out.valid;
         push_data = parse_out.result;
      end
      pend_in = pend_ff;
      if (pend_ff && push) begin
         pend_in = 1'b0;
      end else if (parse_out.extra_empty) begin
         pend_in = 1'b1;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      priority case (1'b1)
         push && !pop: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         push && pop: begin
            if (count_ff == QUEUE_FULL) begin
               head_in = tail_ff;
               tail_in = push_data;
            end else begin
               head_in = push_data;
            end
         end
         !push && pop: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.kind        = head_ff.kind;
   assign rsp_chan.data_byte   = head_ff.data_byte;
   assign rsp_chan.part_index  = head_ff.part_index;
   assign rsp_chan.part_offset = head_ff.part_offset;
   assign rsp_chan.part_size   = head_ff.part_size;
   assign rsp_chan.last        = head_ff.last;

endmodule

// ----- rtl/mprd_parser.sv -----
module mprd_parser
   import mprd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          accept,
   input  logic [7:0]    byte_value,
   input  logic          msg_start,
   output parse_out_type parse_out
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  counter_ff, counter_in;
   logic [31:0] part_count_ff, part_count_in;
   logic [31:0] index_ff, index_in;
   logic [63:0] word_ff, word_in;
   logic [31:0] first_size_ff, first_size_in;
   logic [31:0] remaining_ff, remaining_in;

   phase_type   eff_phase;
   logic [2:0]  eff_counter;
   logic [31:0] eff_part_count;
   logic [31:0] eff_index;
   logic [63:0] eff_word;
   logic [31:0] eff_first_size;
   logic [31:0] eff_remaining;

   logic [63:0] word_shift;
   logic [31:0] index_next;
   logic [31:0] wbxml_len;
   logic [31:0] remaining_dec;
   logic        count_done;
   logic        tuple_done;
   logic        tuples_done;

   // A message start clears the state before the byte is parsed.
   always_comb begin
      if (msg_start) begin
         eff_phase      = PH_COUNT;
         eff_counter    = 3'd0;
         eff_part_count = 32'd0;
         eff_index      = 32'd0;
         eff_word       = 64'd0;
         eff_first_size = 32'd0;
         eff_remaining  = 32'd0;
      end else begin
         eff_phase      = phase_ff;
         eff_counter    = counter_ff;
         eff_part_count = part_count_ff;
         eff_index      = index_ff;
         eff_word       = word_ff;
         eff_first_size = first_size_ff;
         eff_remaining  = remaining_ff;
      end
   end

   // Bytes enter at the top and move down, so after four or eight bytes the
   // little-endian value sits in the upper half or the whole word.
   assign word_shift    = {byte_value, eff_word[63:8]};
   assign index_next    = eff_index + 32'd1;
   assign tuples_done   = (index_next == eff_part_count);
   assign wbxml_len     = (eff_index == 32'd0) ? word_shift[63:32] : eff_first_size;
   assign remaining_dec = eff_remaining - 32'd1;
   assign count_done    = (eff_counter >= COUNT_LAST_BYTE);
   assign tuple_done    = (eff_counter >= TUPLE_LAST_BYTE);

   always_comb begin
      phase_in      = phase_ff;
      counter_in    = counter_ff;
      part_count_in = part_count_ff;
      index_in      = index_ff;
      word_in       = word_ff;
      first_size_in = first_size_ff;
      remaining_in  = remaining_ff;
      if (accept && (msg_start || enable)) begin
         phase_in      = eff_phase;
         counter_in    = eff_counter;
         part_count_in = eff_part_count;
         index_in      = eff_index;
         word_in       = eff_word;
         first_size_in = eff_first_size;
         remaining_in  = eff_remaining;
      end
      if (accept && enable) begin
         unique case (eff_phase)
            PH_COUNT: begin
               word_in = word_shift;
               if (count_done) begin
                  part_count_in = word_shift[63:32];
                  counter_in    = 3'd0;
                  index_in      = 32'd0;
                  phase_in      = (word_shift[63:32] == 32'd0) ? PH_ERROR : PH_TUPLES;
               end else begin
                  counter_in = eff_counter + 3'd1;
               end
            end
            PH_TUPLES: begin
               word_in = word_shift;
               if (tuple_done) begin
                  counter_in = 3'd0;
                  index_in   = index_next;
                  if (eff_index == 32'd0) begin
                     first_size_in = word_shift[63:32];
                  end
                  if (tuples_done) begin
                     remaining_in = wbxml_len;
                     phase_in     = (wbxml_len == 32'd0) ? PH_BODY : PH_WBXML;
                  end
               end else begin
                  counter_in = eff_counter + 3'd1;
               end
            end
            PH_WBXML: begin
               remaining_in = remaining_dec;
               if (remaining_dec == 32'd0) begin
                  phase_in = PH_BODY;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      parse_out             = '0;
      parse_out.result.kind = KIND_TUPLE;
      if (accept && enable) begin
         unique case (eff_phase)
            PH_COUNT: begin
               if (count_done && (word_shift[63:32] == 32'd0)) begin
                  parse_out.valid       = 1'b1;
                  parse_out.result.kind = KIND_ZERO_ERR;
               end
            end
            PH_TUPLES: begin
               if (tuple_done) begin
                  parse_out.valid              = 1'b1;
                  parse_out.result.kind        = KIND_TUPLE;
                  parse_out.result.part_index  = eff_index;
                  parse_out.result.part_offset = word_shift[31:0];
                  parse_out.result.part_size   = word_shift[63:32];
                  parse_out.extra_empty        = tuples_done && (wbxml_len == 32'd0);
               end
            end
            PH_WBXML: begin
               parse_out.valid            = 1'b1;
               parse_out.result.kind      = KIND_WBXML;
               parse_out.result.data_byte = byte_value;
               parse_out.result.last      = (remaining_dec == 32'd0);
            end
            PH_BODY: begin
               parse_out.valid            = 1'b1;
               parse_out.result.kind      = KIND_BODY;
               parse_out.result.data_byte = byte_value;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_COUNT;
         counter_ff    <= 3'd0;
         part_count_ff <= 32'd0;
         index_ff      <= 32'd0;
         word_ff       <= 64'd0;
         first_size_ff <= 32'd0;
         remaining_ff  <= 32'd0;
      end else begin
         phase_ff      <= phase_in;
         counter_ff    <= counter_in;
         part_count_ff <= part_count_in;
         index_ff      <= index_in;
         word_ff       <= word_in;
         first_size_ff <= first_size_in;
         remaining_ff  <= remaining_in;
      end
   end

endmodule

// ----- rtl/mprd_checker.sv -----
module mprd_checker
   import mprd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last
);

   // The response queue is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response word present right after reset");

   // A stalled response word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word withdrawn while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_TUPLE) || (rsp_kind == KIND_WBXML) ||
                    (rsp_kind == KIND_BODY) || (rsp_kind == KIND_ZERO_ERR) ||
                    (rsp_kind == KIND_EMPTY))
      else $error("response kind out of range");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_kind == KIND_WBXML) || (rsp_kind == KIND_EMPTY))
      else $error("last marked on a word that is not WBXML");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_WBXML) && (rsp_kind != KIND_BODY)
         |-> (rsp_data_byte == 8'd0))
      else $error("data byte set on a word that carries no byte");

endmodule

bind multipart_response_deframer_unit mprd_checker u_mprd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_data_byte (rsp_chan.data_byte),
   .rsp_last      (rsp_chan.last)
);
